[sv/iptc_pkg.sv]
`default_nettype none

package iptc_pkg;

  // One input word: a frame byte and its end-of-frame mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // One result word, given once per frame.
  typedef struct packed {
    logic [2:0]  verdict;
    logic [5:0]  priority_res;
    logic        inner_is_ipv6;
    logic [7:0]  l4_protocol;
    logic [6:0]  inner_offset;
    logic [13:0] frame_length;
  } out_word_t;

  // Frame summary handed from the parser to the verdict stage.
  typedef struct packed {
    logic        is_v4;
    logic        is_v6;
    logic        len_outer_ok;
    logic        len_in24_ok;
    logic        len_in44_ok;
    logic [7:0]  next_proto;
    logic [5:0]  priority_val;
    logic [3:0]  inner_version;
    logic [7:0]  inner_proto;
    logic        dest_match;
    logic [13:0] frame_length;
  } sum_t;

  // Configuration port.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IPV4  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IPV6H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IPV6L = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO_MAX  = 2'd3;
  localparam logic [5:0] PRIO_MAX_RESET = 6'd1;

  // Protocol numbers.
  localparam logic [15:0] ETH_IPV4   = 16'h0800;
  localparam logic [15:0] ETH_IPV6   = 16'h86DD;
  localparam logic [7:0]  PROTO_IPIP = 8'd4;
  localparam logic [3:0]  VER_IPV4   = 4'd4;
  localparam logic [3:0]  VER_IPV6   = 4'd6;

  // Byte positions in the frame.
  localparam int POS_ETYPE_HI   = 12;
  localparam int POS_ETYPE_LO   = 13;
  localparam int POS_V6_TC_HI   = 14;
  localparam int POS_TOS        = 15;
  localparam int POS_V6_NEXT    = 20;
  localparam int POS_V4_PROTO   = 23;
  localparam int POS_V4_DST     = 30;
  localparam int POS_V6_DST_HI  = 38;
  localparam int POS_V6_DST_LO  = 46;
  localparam int INNER_V4_OUTER = 34;
  localparam int INNER_V6_OUTER = 54;
  localparam int INNER_V4_PROTO = 9;
  localparam int INNER_V6_NEXT  = 6;
  localparam int INNER_MIN_V4   = 24;
  localparam int INNER_MIN_V6   = 44;
  localparam logic [6:0] INNER_OFF_V4 = 7'd34;
  localparam logic [6:0] INNER_OFF_V6 = 7'd54;

  // Verdict codes.
  localparam logic [2:0] VERDICT_DROP   = 3'd0;
  localparam logic [2:0] VERDICT_ACL    = 3'd1;
  localparam logic [2:0] VERDICT_WRONG  = 3'd2;
  localparam logic [2:0] VERDICT_DIRECT = 3'd3;
  localparam logic [2:0] VERDICT_POLICY = 3'd4;

  // Depth of the queue between parser and verdict stage.
  localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

[sv/ipip_tunnel_packet_classifier_unit.sv]
`default_nettype none

// IP-in-IP tunnel classifier.
// The input channel (in_valid, in_stall, in_word) carries one frame byte per
// word, starting at the Ethernet header; last_byte marks the final byte.
// One result word leaves on the output channel (out_valid, out_stall,
// out_word) per frame, holding the verdict and the parsed header fields.
// Throughput is one byte per cycle while in_stall is low: every byte updates
// the parser state in the cycle it is accepted, and a finished frame summary
// goes into a two-word queue ahead of the verdict stage.
// A frame's summary is registered in the queue, then its verdict in the output register.
// When the receiver stalls, the output register holds its word and the
// queue fills; in_stall rises only when the queue is full.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the own IPv4
// address, both halves of the own IPv6 address and the direct-forwarding
// priority limit; write only while no frame is in flight.
// Reset (rst_n low, synchronous) clears the parser state, empties the queue,
// drops out_valid, zeroes the addresses and sets the priority limit to one.
module ipip_tunnel_packet_classifier_unit import iptc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 16383
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_word_t              in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_word_t                  out_word,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [31:0] own_v4_r;
  logic [63:0] own_v6_hi_r;
  logic [63:0] own_v6_lo_r;
  logic [5:0]  prio_max_r;

  logic q_full, q_empty, push, pop;
  sum_t push_sum, head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_v4_r    <= '0;
      own_v6_hi_r <= '0;
      own_v6_lo_r <= '0;
      prio_max_r  <= PRIO_MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_IPV4:  own_v4_r    <= cfg_data[31:0];
        CFG_OWN_IPV6H: own_v6_hi_r <= cfg_data;
        CFG_OWN_IPV6L: own_v6_lo_r <= cfg_data;
        CFG_PRIO_MAX:  prio_max_r  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;

  iptc_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_word  (in_word),
    .q_full   (q_full),
    .own_v4   (own_v4_r),
    .own_v6_hi(own_v6_hi_r),
    .own_v6_lo(own_v6_lo_r),
    .push     (push),
    .push_sum (push_sum)
  );

  iptc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_sum(push_sum),
    .pop     (pop),
    .full    (q_full),
    .empty   (q_empty),
    .head    (head)
  );

  iptc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .head     (head),
    .prio_max (prio_max_r),
    .out_stall(out_stall),
    .pop      (pop),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  // A summary is never written into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full) else $error("summary pushed into full queue");

  // The verdict stage only takes from a non-empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty) else $error("summary taken from empty queue");

  // A rejected frame reports no parsed fields.
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.verdict == VERDICT_DROP || out_word.verdict == VERDICT_ACL)
    |-> (out_word.priority_res == '0 && out_word.inner_offset == '0
         && out_word.l4_protocol == '0 && !out_word.inner_is_ipv6))
    else $error("rejected frame carries parsed fields");

  // An accepted frame points at one of the two inner header offsets.
  a_offset_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.verdict != VERDICT_DROP && out_word.verdict != VERDICT_ACL
    |-> (out_word.inner_offset == INNER_OFF_V4 || out_word.inner_offset == INNER_OFF_V6))
    else $error("accepted frame with unknown inner offset");

endmodule

`default_nettype wire

[sv/iptc_front.sv]
`default_nettype none

module iptc_front import iptc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 16383
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire in_word_t         in_word,
  input  wire logic             q_full,
  input  wire logic [31:0]      own_v4,
  input  wire logic [63:0]      own_v6_hi,
  input  wire logic [63:0]      own_v6_lo,
  output logic                  push,
  output sum_t                  push_sum
);

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   ek_r, ek_nxt;
  logic [5:0]    prio_r, prio_nxt;
  logic [7:0]    nproto_r, nproto_nxt;
  logic [3:0]    iver_r, iver_nxt;
  logic [7:0]    iproto_r, iproto_nxt;
  logic          dmatch_r, dmatch_nxt;

  logic          accept;
  logic          take;
  logic          is_v4, is_v6, s_v6;
  logic [CW-1:0] inner_pos;
  logic [CW-1:0] thr;
  logic [CW-1:0] off;
  logic [7:0]    b;
  logic [7:0]    want;
  logic          cmp;

  assign accept = in_valid && !q_full;
  assign b      = in_word.data_byte;
  assign is_v4  = (ek_r == ETH_IPV4);
  assign is_v6  = (ek_r == ETH_IPV6);
  assign inner_pos = is_v6 ? CW'(INNER_V6_OUTER) : CW'(INNER_V4_OUTER);
  assign take   = accept && (cnt_r < CW'(MAX_FRAME_BYTES));

  // Expected destination byte at the current position, if any.
  always_comb begin
    want = 8'h00;
    cmp  = 1'b0;
    off  = '0;
    if (is_v4 && cnt_r >= CW'(POS_V4_DST) && cnt_r <= CW'(POS_V4_DST + 3)) begin
      off  = cnt_r - CW'(POS_V4_DST);
      want = own_v4[{~off[1:0], 3'b000} +: 8];
      cmp  = 1'b1;
    end else if (is_v6 && cnt_r >= CW'(POS_V6_DST_HI)
                 && cnt_r <= CW'(POS_V6_DST_HI + 7)) begin
      off  = cnt_r - CW'(POS_V6_DST_HI);
      want = own_v6_hi[{~off[2:0], 3'b000} +: 8];
      cmp  = 1'b1;
    end else if (is_v6 && cnt_r >= CW'(POS_V6_DST_LO)
                 && cnt_r <= CW'(POS_V6_DST_LO + 7)) begin
      off  = cnt_r - CW'(POS_V6_DST_LO);
      want = own_v6_lo[{~off[2:0], 3'b000} +: 8];
      cmp  = 1'b1;
    end
  end

  // Header field capture for the byte at the current position.
  always_comb begin
    cnt_nxt    = cnt_r;
    ek_nxt     = ek_r;
    prio_nxt   = prio_r;
    nproto_nxt = nproto_r;
    iver_nxt   = iver_r;
    iproto_nxt = iproto_r;
    dmatch_nxt = dmatch_r;
    if (take) begin
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(POS_ETYPE_HI)) begin
        ek_nxt = {b, 8'h00};
      end else if (cnt_r == CW'(POS_ETYPE_LO)) begin
        ek_nxt = {ek_r[15:8], b};
      end
      if (is_v4 && cnt_r == CW'(POS_TOS)) begin
        prio_nxt = b[7:2];
      end
      if (is_v6 && cnt_r == CW'(POS_V6_TC_HI)) begin
        prio_nxt = {b[3:0], 2'b00};
      end
      if (is_v6 && cnt_r == CW'(POS_TOS)) begin
        prio_nxt = {prio_r[5:2], b[7:6]};
      end
      if ((is_v4 && cnt_r == CW'(POS_V4_PROTO)) || (is_v6 && cnt_r == CW'(POS_V6_NEXT))) begin
        nproto_nxt = b;
      end
      if ((is_v4 || is_v6) && cnt_r == inner_pos) begin
        iver_nxt = b[7:4];
      end
      if ((is_v4 || is_v6) && iver_r == VER_IPV4
          && cnt_r == inner_pos + CW'(INNER_V4_PROTO)) begin
        iproto_nxt = b;
      end
      if ((is_v4 || is_v6) && iver_r == VER_IPV6
          && cnt_r == inner_pos + CW'(INNER_V6_NEXT)) begin
        iproto_nxt = b;
      end
      if (cmp && want != b) begin
        dmatch_nxt = 1'b0;
      end
    end
  end

  // Frame summary including the last byte's own effect.
  assign s_v6 = (ek_nxt == ETH_IPV6);
  assign thr  = s_v6 ? CW'(INNER_V6_OUTER) : CW'(INNER_V4_OUTER);

  always_comb begin
    push_sum.is_v4         = (ek_nxt == ETH_IPV4);
    push_sum.is_v6         = s_v6;
    push_sum.len_outer_ok  = (cnt_nxt >= thr);
    push_sum.len_in24_ok   = (cnt_nxt >= thr + CW'(INNER_MIN_V4));
    push_sum.len_in44_ok   = (cnt_nxt >= thr + CW'(INNER_MIN_V6));
    push_sum.next_proto    = nproto_nxt;
    push_sum.priority_val  = prio_nxt;
    push_sum.inner_version = iver_nxt;
    push_sum.inner_proto   = iproto_nxt;
    push_sum.dest_match    = dmatch_nxt;
    push_sum.frame_length  = 14'(cnt_nxt);
  end

  assign push = accept && in_word.last_byte;

  // Frame state: cleared on reset and after the last byte of each frame.
  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      cnt_r    <= '0;
      ek_r     <= '0;
      prio_r   <= '0;
      nproto_r <= '0;
      iver_r   <= '0;
      iproto_r <= '0;
      dmatch_r <= 1'b1;
    end else begin
      cnt_r    <= cnt_nxt;
      ek_r     <= ek_nxt;
      prio_r   <= prio_nxt;
      nproto_r <= nproto_nxt;
      iver_r   <= iver_nxt;
      iproto_r <= iproto_nxt;
      dmatch_r <= dmatch_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/iptc_queue.sv]
`default_nettype none

module iptc_queue import iptc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire sum_t push_sum,
  input  wire logic pop,
  output logic      full,
  output logic      empty,
  output sum_t      head
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  sum_t          ent_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] cnt_r;

  assign full  = (cnt_r == NW'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = ent_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_sum;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + NW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - NW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[sv/iptc_back.sv]
`default_nettype none

module iptc_back import iptc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_empty,
  input  wire sum_t       head,
  input  wire logic [5:0] prio_max,
  input  wire logic       out_stall,
  output logic            pop,
  output logic            out_valid,
  output out_word_t       out_word
);

  logic      out_valid_r;
  out_word_t out_word_r, res_nxt;
  logic      ok;

  // Length, protocol and version checks.
  always_comb begin
    ok = (head.is_v4 || head.is_v6)
         && head.len_outer_ok
         && (head.next_proto == PROTO_IPIP)
         && head.len_in24_ok
         && !(head.inner_version == VER_IPV6 && !head.len_in44_ok)
         && (head.inner_version == VER_IPV4 || head.inner_version == VER_IPV6);
  end

  // Verdict and reported fields.
  always_comb begin
    res_nxt = '0;
    res_nxt.frame_length = head.frame_length;
    if (!ok) begin
      res_nxt.verdict = head.is_v6 ? VERDICT_ACL : VERDICT_DROP;
    end else begin
      priority if (!head.dest_match) begin
        res_nxt.verdict = VERDICT_WRONG;
      end else if (head.priority_val <= prio_max) begin
        res_nxt.verdict = VERDICT_DIRECT;
      end else begin
        res_nxt.verdict = VERDICT_POLICY;
      end
      res_nxt.priority_res  = head.priority_val;
      res_nxt.inner_is_ipv6 = (head.inner_version == VER_IPV6);
      res_nxt.l4_protocol   = head.inner_proto;
      res_nxt.inner_offset  = head.is_v6 ? INNER_OFF_V6 : INNER_OFF_V4;
    end
  end

  // Take the next summary whenever the output register is free.
  assign pop = !q_empty && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

[dv/tb_ipip_tunnel_packet_classifier_unit.sv]
`timescale 1ns / 1ps

module tb_ipip_tunnel_packet_classifier_unit;
  import iptc_pkg::*;

  localparam int MAX_FRAME_BYTES = 16383;
  localparam int HOLD_CYCLES     = 400;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 4;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_word;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ipip_tunnel_packet_classifier_unit #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Own copy of the configuration registers.
  logic [31:0] own_v4;
  logic [63:0] own_v6_hi;
  logic [63:0] own_v6_lo;
  logic [5:0]  prio_limit;

  // Own copy of the per-frame parser state.
  int          frame_pos;
  logic [15:0] eth_type;
  logic [5:0]  outer_prio;
  logic [7:0]  outer_proto;
  logic [3:0]  inner_ver;
  logic [7:0]  inner_l4;
  bit          addr_match;

  out_word_t   pending_verdicts[$];
  logic [7:0]  frame_bytes[$];
  int          mismatches;
  int          bytes_accepted;
  int          tx_gap_pct;
  int          rx_stall_pct;
  bit          hold_output;

  function automatic void clear_frame_state();
    frame_pos   = 0;
    eth_type    = '0;
    outer_prio  = '0;
    outer_proto = '0;
    inner_ver   = '0;
    inner_l4    = '0;
    addr_match  = 1'b1;
  endfunction

  // Feeds one accepted byte through the parser; returns 1 when the byte
  // closes the frame, with the verdict word that the block must give.
  function automatic bit classify_byte(input logic [7:0] b, input logic last,
                                       output out_word_t summary);
    int pos;
    int inner;
    int need;
    bit is4;
    bit is6;
    bit ok;
    summary = '0;
    if (frame_pos < MAX_FRAME_BYTES) begin
      pos   = frame_pos;
      is4   = (eth_type == ETH_IPV4);
      is6   = (eth_type == ETH_IPV6);
      inner = is6 ? INNER_V6_OUTER : INNER_V4_OUTER;
      if (pos == POS_ETYPE_HI) begin
        eth_type = {b, 8'h00};
      end else if (pos == POS_ETYPE_LO) begin
        eth_type[7:0] = b;
      end
      // The IPv6 traffic class straddles the first two header bytes.
      if (is4 && pos == POS_TOS) outer_prio = b[7:2];
      if (is6 && pos == POS_V6_TC_HI) outer_prio = {b[3:0], 2'b00};
      if (is6 && pos == POS_TOS) outer_prio = {outer_prio[5:2], b[7:6]};
      if ((is4 && pos == POS_V4_PROTO) || (is6 && pos == POS_V6_NEXT)) outer_proto = b;
      if ((is4 || is6) && pos == inner) inner_ver = b[7:4];
      if ((is4 || is6) && inner_ver == VER_IPV4 && pos == inner + INNER_V4_PROTO)
        inner_l4 = b;
      if ((is4 || is6) && inner_ver == VER_IPV6 && pos == inner + INNER_V6_NEXT)
        inner_l4 = b;
      // Any differing destination byte spoils the address match.
      if (is4 && pos >= POS_V4_DST && pos < POS_V4_DST + 4 &&
          b != own_v4[8 * (POS_V4_DST + 3 - pos) +: 8])
        addr_match = 1'b0;
      if (is6 && pos >= POS_V6_DST_HI && pos < POS_V6_DST_HI + 8 &&
          b != own_v6_hi[8 * (POS_V6_DST_HI + 7 - pos) +: 8])
        addr_match = 1'b0;
      if (is6 && pos >= POS_V6_DST_LO && pos < POS_V6_DST_LO + 8 &&
          b != own_v6_lo[8 * (POS_V6_DST_LO + 7 - pos) +: 8])
        addr_match = 1'b0;
      frame_pos++;
    end
    if (!last) return 1'b0;

    // End of frame: length rules first, then destination and priority.
    is6   = (eth_type == ETH_IPV6);
    inner = is6 ? INNER_V6_OUTER : INNER_V4_OUTER;
    need  = inner + INNER_MIN_V4;
    ok    = (eth_type == ETH_IPV4) || is6;
    if (ok && frame_pos < inner) ok = 1'b0;
    if (ok && outer_proto != PROTO_IPIP) ok = 1'b0;
    if (ok && frame_pos < need) ok = 1'b0;
    if (ok && inner_ver == VER_IPV6 && frame_pos < inner + INNER_MIN_V6) ok = 1'b0;
    if (ok && inner_ver != VER_IPV4 && inner_ver != VER_IPV6) ok = 1'b0;
    summary.frame_length = frame_pos[13:0];
    if (!ok) begin
      summary.verdict = is6 ? VERDICT_ACL : VERDICT_DROP;
    end else begin
      if (!addr_match) begin
        summary.verdict = VERDICT_WRONG;
      end else if (outer_prio <= prio_limit) begin
        summary.verdict = VERDICT_DIRECT;
      end else begin
        summary.verdict = VERDICT_POLICY;
      end
      summary.priority_res  = outer_prio;
      summary.inner_is_ipv6 = (inner_ver == VER_IPV6);
      summary.l4_protocol   = inner_l4;
      summary.inner_offset  = is6 ? INNER_OFF_V6 : INNER_OFF_V4;
    end
    clear_frame_state();
    return 1'b1;
  endfunction

  function automatic void put_byte(input int pos, input logic [7:0] v);
    if (pos < frame_bytes.size()) frame_bytes[pos] = v;
  endfunction

  // Builds a frame of random bytes with the given header fields laid over
  // it. A negative flip keeps the destination equal to the own address;
  // otherwise it selects the destination byte to corrupt.
  function automatic void build_frame(input logic [15:0] etype, input logic [5:0] prio,
                                      input logic [7:0] oproto, input int flip,
                                      input logic [3:0] iver, input logic [7:0] l4,
                                      input int len);
    int          i;
    int          inner;
    logic [31:0] rnd;
    logic [7:0]  spoil;
    logic [7:0]  d;
    frame_bytes.delete();
    for (i = 0; i < len; i++) begin
      rnd = $urandom;
      frame_bytes.push_back(rnd[7:0]);
    end
    rnd   = $urandom;
    spoil = 8'($urandom_range(1, 255));
    inner = (etype == ETH_IPV6) ? INNER_V6_OUTER : INNER_V4_OUTER;
    put_byte(POS_ETYPE_HI, etype[15:8]);
    put_byte(POS_ETYPE_LO, etype[7:0]);
    if (etype == ETH_IPV4) begin
      put_byte(POS_TOS, {prio, rnd[1:0]});
      put_byte(POS_V4_PROTO, oproto);
      for (i = 0; i < 4; i++) begin
        d = own_v4[8 * (3 - i) +: 8];
        if (flip >= 0 && i == flip % 4) d = d ^ spoil;
        put_byte(POS_V4_DST + i, d);
      end
    end else if (etype == ETH_IPV6) begin
      put_byte(POS_V6_TC_HI, {rnd[7:4], prio[5:2]});
      put_byte(POS_TOS, {prio[1:0], rnd[13:8]});
      put_byte(POS_V6_NEXT, oproto);
      for (i = 0; i < 16; i++) begin
        d = (i < 8) ? own_v6_hi[8 * (7 - i) +: 8] : own_v6_lo[8 * (15 - i) +: 8];
        if (flip >= 0 && i == flip % 16) d = d ^ spoil;
        put_byte(POS_V6_DST_HI + i, d);
      end
    end
    put_byte(inner, {iver, rnd[19:16]});
    if (iver == VER_IPV4) put_byte(inner + INNER_V4_PROTO, l4);
    if (iver == VER_IPV6) put_byte(inner + INNER_V6_NEXT, l4);
  endfunction

  // Mostly well-formed tunnel frames with random content; the rest are
  // frames with broken fields, short lengths or no IP at all.
  function automatic void build_random_frame();
    logic [31:0] r;
    logic [15:0] etype;
    logic [7:0]  oproto;
    logic [3:0]  iver;
    int          flip;
    int          need;
    int          len;
    r = $urandom;
    if (r[7:0] < 8'd100) begin
      etype = ETH_IPV4;
    end else if (r[7:0] < 8'd205) begin
      etype = ETH_IPV6;
    end else begin
      etype = r[31:16];
    end
    r      = $urandom;
    oproto = ($urandom_range(0, 99) < 88) ? PROTO_IPIP : r[7:0];
    flip   = ($urandom_range(0, 99) < 80) ? -1 : int'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < 45) begin
      iver = VER_IPV4;
    end else if ($urandom_range(0, 99) < 82) begin
      iver = VER_IPV6;
    end else begin
      iver = r[11:8];
    end
    need = ((etype == ETH_IPV6) ? INNER_V6_OUTER : INNER_V4_OUTER) +
           ((iver == VER_IPV6) ? INNER_MIN_V6 : INNER_MIN_V4);
    if ($urandom_range(0, 99) < 70) begin
      len = need + $urandom_range(0, 30);
    end else if ($urandom_range(0, 99) < 40) begin
      len = need - 1 + $urandom_range(0, 1);
    end else begin
      len = $urandom_range(1, need + 4);
    end
    build_frame(etype, r[21:16], oproto, flip, iver, r[31:24], len);
  endfunction

  // Offers one word and waits until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_word_t  w;
    out_word_t verdict;
    w.data_byte = b;
    w.last_byte = last;
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    bytes_accepted++;
    if (classify_byte(b, last, verdict)) pending_verdicts.push_back(verdict);
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_bytes.size(); i++) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Lets every outstanding verdict arrive and then keeps the input quiet, so that
  // the block is idle before the registers change.
  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      CFG_OWN_IPV4:  own_v4     = value[31:0];
      CFG_OWN_IPV6H: own_v6_hi  = value;
      CFG_OWN_IPV6L: own_v6_lo  = value;
      CFG_PRIO_MAX:  prio_limit = value[5:0];
      default: ;
    endcase
  endtask

  task automatic program_registers(input logic [63:0] v4_word, input logic [63:0] hi_word,
                                   input logic [63:0] lo_word, input logic [63:0] prio_word);
    write_reg(CFG_OWN_IPV4, v4_word);
    write_reg(CFG_OWN_IPV6H, hi_word);
    write_reg(CFG_OWN_IPV6L, lo_word);
    write_reg(CFG_PRIO_MAX, prio_word);
    cfg_we <= 1'b0;
  endtask

  // Frames that must fail parsing: truncated headers, an unknown ether type,
  // wrong outer protocol, a length one short of a limit, bad inner version.
  task automatic test_parse_failures();
    build_frame(ETH_IPV4, 6'd0, PROTO_IPIP, -1, VER_IPV4, 8'd6, 1);
    send_frame();
    build_frame(ETH_IPV6, 6'd0, PROTO_IPIP, -1, VER_IPV4, 8'd6, 13);
    send_frame();
    build_frame(16'h0000, 6'd5, PROTO_IPIP, -1, VER_IPV4, 8'd6, 20);
    send_frame();
    build_frame(ETH_IPV6, 6'd0, PROTO_IPIP, -1, VER_IPV4, 8'd6, INNER_V6_OUTER - 1);
    send_frame();
    build_frame(ETH_IPV4, 6'd0, 8'd6, -1, VER_IPV4, 8'd17,
                INNER_V4_OUTER + INNER_MIN_V4);
    send_frame();
    build_frame(ETH_IPV4, 6'd0, PROTO_IPIP, -1, VER_IPV4, 8'd6,
                INNER_V4_OUTER + INNER_MIN_V4 - 1);
    send_frame();
    build_frame(ETH_IPV4, 6'd0, PROTO_IPIP, -1, 4'd0, 8'd6,
                INNER_V4_OUTER + INNER_MIN_V4);
    send_frame();
    wait_for_verdicts();
  endtask

  // Well-formed tunnels at their minimum lengths, priorities around the
  // limit, and a spoiled destination.
  task automatic test_tunnel_verdicts();
    build_frame(ETH_IPV4, 6'd0, PROTO_IPIP, -1, VER_IPV4, 8'h00,
                INNER_V4_OUTER + INNER_MIN_V4);
    send_frame();
    build_frame(ETH_IPV4, 6'd1, PROTO_IPIP, -1, VER_IPV6, 8'hFF,
                INNER_V4_OUTER + INNER_MIN_V6);
    send_frame();
    build_frame(ETH_IPV6, 6'd63, PROTO_IPIP, -1, VER_IPV4, 8'd17,
                INNER_V6_OUTER + INNER_MIN_V4);
    send_frame();
    build_frame(ETH_IPV4, 6'd0, PROTO_IPIP, 3, VER_IPV4, 8'd6,
                INNER_V4_OUTER + INNER_MIN_V4);
    send_frame();
    wait_for_verdicts();
  endtask

  task automatic test_random_traffic(input int frame_goal, input int byte_goal);
    int frames;
    int first_byte;
    frames     = 0;
    first_byte = bytes_accepted;
    while (frames < frame_goal || bytes_accepted - first_byte < byte_goal) begin
      build_random_frame();
      send_frame();
      frames++;
    end
    wait_for_verdicts();
  endtask

  // The receiver holds off for a long stretch while short frames keep
  // arriving, so the result queue fills and the input is stalled.
  task automatic test_output_backpressure();
    int          n;
    logic [31:0] r;
    hold_output = 1'b1;
    for (n = 0; n < 10; n++) begin
      r = $urandom;
      build_frame(r[15:0], r[21:16], PROTO_IPIP, -1, VER_IPV4, r[31:24],
                  $urandom_range(1, 16));
      send_frame();
    end
    wait_for_verdicts();
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Every result word taken by the receiver is matched with the oldest
  // outstanding verdict.
  always @(posedge clk) begin : verdict_check
    out_word_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: verdict word %h arrived with none outstanding", $time, out_word);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("verdict", 32'(want.verdict), 32'(out_word.verdict));
        check_field("priority_res", 32'(want.priority_res), 32'(out_word.priority_res));
        check_field("inner_is_ipv6", 32'(want.inner_is_ipv6),
                    32'(out_word.inner_is_ipv6));
        check_field("l4_protocol", 32'(want.l4_protocol), 32'(out_word.l4_protocol));
        check_field("inner_offset", 32'(want.inner_offset), 32'(out_word.inner_offset));
        check_field("frame_length", 32'(want.frame_length), 32'(out_word.frame_length));
      end
    end
  end

  // Receiver: random stalls, or one long hold-off when asked for.
  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        hold_output = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Ends the run if no word moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
    $display("ipip_tunnel_packet_classifier_unit verification failed");
    $finish;
  end

  initial begin : sequencer
    logic [63:0] word_a;
    logic [63:0] word_b;
    logic [63:0] word_c;
    logic [63:0] word_d;
    logic [31:0] pick;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_word      <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_OWN_IPV4;
    cfg_data     <= '0;
    mismatches     = 0;
    bytes_accepted = 0;
    hold_output    = 1'b0;
    tx_gap_pct     = 8;
    rx_stall_pct   = 58;
    own_v4         = '0;
    own_v6_hi      = '0;
    own_v6_lo      = '0;
    prio_limit     = PRIO_MAX_RESET;
    clear_frame_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames run on the reset register values.
    test_parse_failures();
    test_tunnel_verdicts();

    // All-ones and all-zeros addresses, lowest priority limit; upper bits
    // of the narrow registers carry junk that must be ignored.
    word_a = {$urandom, 32'hFFFF_FFFF};
    word_d = {$urandom, $urandom};
    word_d[5:0] = 6'd0;
    program_registers(word_a, '1, '0, word_d);
    test_random_traffic(1, 60);

    tx_gap_pct   = 58;
    rx_stall_pct = 8;
    word_a = {$urandom, 32'h0000_0000};
    word_d = {$urandom, $urandom};
    word_d[5:0] = 6'd63;
    program_registers(word_a, '0, '1, word_d);
    test_random_traffic(1, 60);

    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    word_a = {$urandom, $urandom};
    word_b = {$urandom, $urandom};
    word_c = {$urandom, $urandom};
    word_d = {$urandom, $urandom};
    pick   = $urandom_range(1, 62);
    word_d[5:0] = pick[5:0];
    program_registers(word_a, word_b, word_c, word_d);
    test_random_traffic(1, 60);
    test_output_backpressure();

    if (pending_verdicts.size() != 0) begin
      $display("%0t: %0d verdicts never arrived", $time, pending_verdicts.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("ipip_tunnel_packet_classifier_unit verification clean");
    end else begin
      $display("ipip_tunnel_packet_classifier_unit verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/iptc_pkg.sv
sv/iptc_front.sv
sv/iptc_queue.sv
sv/iptc_back.sv
sv/ipip_tunnel_packet_classifier_unit.sv
dv/tb_ipip_tunnel_packet_classifier_unit.sv
